// File: rtl/mhd_limited_slope_assert.svh
// Assertion macros shared by the limited slope RTL
`ifndef MHD_LIMITED_SLOPE_ASSERT_SVH
`define MHD_LIMITED_SLOPE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define MLS_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("mls assertion failed: same-cycle implication");

// next-cycle implication, disabled during reset
`define MLS_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("mls assertion failed: next-cycle implication");

`endif

// File: rtl/mls_pkg.sv
// Shared constants and types for the limited slope pipeline
`default_nettype none

package mls_pkg;

    localparam int MLS_DATA_BITS = 32;

    localparam logic [1:0] KIND_MINMOD = 2'd1;
    localparam logic [1:0] KIND_MC     = 2'd2;

    localparam logic [1:0] REQ_SCALAR  = 2'd0;
    localparam logic [1:0] REQ_MAG     = 2'd1;
    localparam logic [1:0] REQ_FACE    = 2'd2;

    typedef enum logic [1:0] {
        MODE_ZERO,
        MODE_LIMIT,
        MODE_FACE
    } mode_t;

    typedef struct packed {
        mode_t mode;
        logic  k2;
    } mls_ctl_t;

endpackage

`default_nettype wire

// File: rtl/mls_face.sv
// Stage 1: request decode and face averaging
`default_nettype none

module mls_face
    import mls_pkg::*;
#(
    parameter int DATA_BITS = MLS_DATA_BITS
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic [1:0]                  kind,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [1:0]                  req_type,
    input  wire logic signed [DATA_BITS-1:0] centre_a,
    input  wire logic signed [DATA_BITS-1:0] plus_a,
    input  wire logic signed [DATA_BITS-1:0] minus_a,
    input  wire logic signed [DATA_BITS-1:0] centre_b,
    input  wire logic signed [DATA_BITS-1:0] plus_b,
    input  wire logic signed [DATA_BITS-1:0] minus_b,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic signed [DATA_BITS-1:0]      out_c,
    output logic signed [DATA_BITS-1:0]      out_p,
    output logic signed [DATA_BITS-1:0]      out_m,
    output mls_ctl_t                         out_ctl
);

    logic                        valid_reg;
    logic signed [DATA_BITS-1:0] c_reg, p_reg, m_reg;
    logic signed [DATA_BITS-1:0] c_next, p_next, m_next;
    mls_ctl_t                    ctl_reg, ctl_next;
    logic        [DATA_BITS:0]   sum_c, sum_p, sum_m;
    logic                        kind_ok;

    assign sum_c = {centre_a[DATA_BITS-1], centre_a} + {centre_b[DATA_BITS-1], centre_b};
    assign sum_p = {plus_a[DATA_BITS-1], plus_a} + {plus_b[DATA_BITS-1], plus_b};
    assign sum_m = {minus_a[DATA_BITS-1], minus_a} + {minus_b[DATA_BITS-1], minus_b};
    assign kind_ok = (kind == KIND_MINMOD) || (kind == KIND_MC);

    always_comb begin
        c_next = centre_a;
        p_next = plus_a;
        m_next = minus_a;
        ctl_next.k2 = (kind == KIND_MC);
        ctl_next.mode = MODE_ZERO;
        case (req_type)
            REQ_SCALAR: begin
                ctl_next.mode = kind_ok ? MODE_LIMIT : MODE_ZERO;
            end
            REQ_MAG: begin
                ctl_next.mode = kind_ok ? MODE_LIMIT : MODE_ZERO;
                // floor of the face average
                c_next = sum_c[DATA_BITS:1];
                p_next = sum_p[DATA_BITS:1];
                m_next = sum_m[DATA_BITS:1];
            end
            REQ_FACE: begin
                // p - m downstream yields right face minus left face
                ctl_next.mode = MODE_FACE;
                p_next = centre_b;
                m_next = centre_a;
            end
            default: begin
                ctl_next.mode = MODE_ZERO;
            end
        endcase
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            c_reg   <= c_next;
            p_reg   <= p_next;
            m_reg   <= m_next;
            ctl_reg <= ctl_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_c     = c_reg;
    assign out_p     = p_reg;
    assign out_m     = m_reg;
    assign out_ctl   = ctl_reg;

endmodule

`default_nettype wire

// File: rtl/mls_delta.sv
// Stage 2: one-sided, scaled and central differences
`default_nettype none

module mls_delta
    import mls_pkg::*;
#(
    parameter int DATA_BITS = MLS_DATA_BITS
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic signed [DATA_BITS-1:0] in_c,
    input  wire logic signed [DATA_BITS-1:0] in_p,
    input  wire logic signed [DATA_BITS-1:0] in_m,
    input  wire mls_ctl_t                    in_ctl,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic signed [DATA_BITS+1:0]      out_dl,
    output logic signed [DATA_BITS+1:0]      out_dr,
    output logic signed [DATA_BITS:0]        out_dd,
    output mode_t                            out_mode
);

    logic                        valid_reg;
    logic signed [DATA_BITS+1:0] dl_reg, dr_reg, dl_next, dr_next;
    logic signed [DATA_BITS:0]   dd_reg, dd_next;
    mode_t                       mode_reg;
    logic signed [DATA_BITS:0]   c_ext, p_ext, m_ext, dl0, dr0;

    assign c_ext = {in_c[DATA_BITS-1], in_c};
    assign p_ext = {in_p[DATA_BITS-1], in_p};
    assign m_ext = {in_m[DATA_BITS-1], in_m};
    assign dl0   = c_ext - m_ext;
    assign dr0   = p_ext - c_ext;
    assign dd_next = p_ext - m_ext;
    // MC doubles the one-sided differences
    assign dl_next = in_ctl.k2 ? {dl0, 1'b0} : {dl0[DATA_BITS], dl0};
    assign dr_next = in_ctl.k2 ? {dr0, 1'b0} : {dr0[DATA_BITS], dr0};

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            dl_reg   <= dl_next;
            dr_reg   <= dr_next;
            dd_reg   <= dd_next;
            mode_reg <= in_ctl.mode;
        end
    end

    assign out_valid = valid_reg;
    assign out_dl    = dl_reg;
    assign out_dr    = dr_reg;
    assign out_dd    = dd_reg;
    assign out_mode  = mode_reg;

endmodule

`default_nettype wire

// File: rtl/mls_limit.sv
// Stages 3 to 5: magnitudes, limiter minimum and signed result
`default_nettype none

module mls_limit
    import mls_pkg::*;
#(
    parameter int DATA_BITS = MLS_DATA_BITS
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic signed [DATA_BITS+1:0] in_dl,
    input  wire logic signed [DATA_BITS+1:0] in_dr,
    input  wire logic signed [DATA_BITS:0]   in_dd,
    input  wire mode_t                       in_mode,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic signed [DATA_BITS:0]        out_slope
);

    // stage 3
    logic                      v3_reg, rdy3;
    logic [DATA_BITS:0]        a3_reg, b3_reg, a3_next, b3_next;
    logic [DATA_BITS-2:0]      h3_reg, h3_next;
    logic                      zero3_reg, zero3_next, neg3_reg;
    logic signed [DATA_BITS:0] dd3_reg;
    mode_t                     mode3_reg;
    logic [DATA_BITS+1:0]      dl_neg, dr_neg;
    logic [DATA_BITS:0]        dd_neg;
    logic [DATA_BITS-1:0]      dd_mag;

    // stage 4
    logic                      v4_reg, rdy4;
    logic [DATA_BITS:0]        lim4_reg, lim4_next;
    logic [DATA_BITS-2:0]      h4_reg;
    logic                      neg4_reg;
    logic signed [DATA_BITS:0] dd4_reg;
    mode_t                     mode4_reg;

    // stage 5
    logic                      v5_reg, rdy5;
    logic signed [DATA_BITS:0] res5_reg, res5_next;
    logic [DATA_BITS-2:0]      mag5;
    logic [DATA_BITS:0]        mag5_ext;

    assign dl_neg = -in_dl;
    assign dr_neg = -in_dr;
    assign dd_neg = -in_dd;
    assign a3_next = in_dl[DATA_BITS+1] ? dl_neg[DATA_BITS:0] : in_dl[DATA_BITS:0];
    assign b3_next = in_dr[DATA_BITS+1] ? dr_neg[DATA_BITS:0] : in_dr[DATA_BITS:0];
    assign dd_mag  = in_dd[DATA_BITS] ? dd_neg[DATA_BITS-1:0] : in_dd[DATA_BITS-1:0];
    assign h3_next = dd_mag[DATA_BITS-1:1];
    assign zero3_next = (in_dl == '0) || (in_dr == '0) ||
                        (in_dl[DATA_BITS+1] != in_dr[DATA_BITS+1]);

    assign lim4_next = zero3_reg ? '0 : ((a3_reg < b3_reg) ? a3_reg : b3_reg);

    assign mag5 = (lim4_reg < {2'b00, h4_reg}) ? lim4_reg[DATA_BITS-2:0] : h4_reg;
    assign mag5_ext = {2'b00, mag5};

    always_comb begin
        case (mode4_reg)
            MODE_LIMIT: res5_next = neg4_reg ? -mag5_ext : mag5_ext;
            MODE_FACE:  res5_next = dd4_reg;
            default:    res5_next = '0;
        endcase
    end

    assign rdy5 = !v5_reg || out_ready;
    assign rdy4 = !v4_reg || rdy5;
    assign rdy3 = !v3_reg || rdy4;
    assign in_ready = rdy3;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (rdy3) begin
                v3_reg <= in_valid;
            end
            if (rdy4) begin
                v4_reg <= v3_reg;
            end
            if (rdy5) begin
                v5_reg <= v4_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy3 && in_valid) begin
            a3_reg    <= a3_next;
            b3_reg    <= b3_next;
            h3_reg    <= h3_next;
            zero3_reg <= zero3_next;
            neg3_reg  <= in_dd[DATA_BITS];
            dd3_reg   <= in_dd;
            mode3_reg <= in_mode;
        end
        if (rdy4 && v3_reg) begin
            lim4_reg  <= lim4_next;
            h4_reg    <= h3_reg;
            neg4_reg  <= neg3_reg;
            dd4_reg   <= dd3_reg;
            mode4_reg <= mode3_reg;
        end
        if (rdy5 && v4_reg) begin
            res5_reg <= res5_next;
        end
    end

    assign out_valid = v5_reg;
    assign out_slope = res5_reg;

endmodule

`default_nettype wire

// File: rtl/mhd_limited_slope.sv
// Top level of the minmod / MC limited slope pipeline
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | s_req_type, s_centre_a .. s_minus_b
//  m_      | out       | m_valid / m_ready  | m_slope
//
// Five register stages: decode/average, differences, magnitudes, minimum, result.
// One transfer per cycle in each direction when the output does not stall.
// Each stage reloads when empty or when the stage after it moves, so stalls
// fill bubbles and lose nothing. Reset is synchronous: it empties every stage
// and sets the limiter to minmod. No clearing pass is needed.
`default_nettype none

`include "mhd_limited_slope_assert.svh"

module mhd_limited_slope
    import mls_pkg::*;
#(
    parameter int DATA_BITS = MLS_DATA_BITS
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_wr_en,
    input  wire logic [1:0]                  cfg_wr_data,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [1:0]                  s_req_type,
    input  wire logic signed [DATA_BITS-1:0] s_centre_a,
    input  wire logic signed [DATA_BITS-1:0] s_plus_a,
    input  wire logic signed [DATA_BITS-1:0] s_minus_a,
    input  wire logic signed [DATA_BITS-1:0] s_centre_b,
    input  wire logic signed [DATA_BITS-1:0] s_plus_b,
    input  wire logic signed [DATA_BITS-1:0] s_minus_b,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic signed [DATA_BITS:0]        m_slope
);

    logic [1:0]                  kind_reg;
    logic                        face_valid, face_ready;
    logic signed [DATA_BITS-1:0] face_c, face_p, face_m;
    mls_ctl_t                    face_ctl;
    logic                        delta_valid, delta_ready;
    logic signed [DATA_BITS+1:0] delta_dl, delta_dr;
    logic signed [DATA_BITS:0]   delta_dd;
    mode_t                       delta_mode;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg <= KIND_MINMOD;
        end else if (cfg_wr_en) begin
            kind_reg <= cfg_wr_data;
        end
    end

    mls_face #(.DATA_BITS(DATA_BITS)) u_face (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .kind      (kind_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .req_type  (s_req_type),
        .centre_a  (s_centre_a),
        .plus_a    (s_plus_a),
        .minus_a   (s_minus_a),
        .centre_b  (s_centre_b),
        .plus_b    (s_plus_b),
        .minus_b   (s_minus_b),
        .out_valid (face_valid),
        .out_ready (face_ready),
        .out_c     (face_c),
        .out_p     (face_p),
        .out_m     (face_m),
        .out_ctl   (face_ctl)
    );

    mls_delta #(.DATA_BITS(DATA_BITS)) u_delta (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (face_valid),
        .in_ready  (face_ready),
        .in_c      (face_c),
        .in_p      (face_p),
        .in_m      (face_m),
        .in_ctl    (face_ctl),
        .out_valid (delta_valid),
        .out_ready (delta_ready),
        .out_dl    (delta_dl),
        .out_dr    (delta_dr),
        .out_dd    (delta_dd),
        .out_mode  (delta_mode)
    );

    mls_limit #(.DATA_BITS(DATA_BITS)) u_limit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (delta_valid),
        .in_ready  (delta_ready),
        .in_dl     (delta_dl),
        .in_dr     (delta_dr),
        .in_dd     (delta_dd),
        .in_mode   (delta_mode),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_slope (m_slope)
    );

    // backpressure reaches the input only when the output holds a result
    `MLS_ASSERT_IMP(a_full_needs_output, aclk, aresetn, !s_ready, m_valid)
    // a completed output transfer frees a slot all the way back
    `MLS_ASSERT_IMP(a_drain_frees_input, aclk, aresetn, m_valid && m_ready, s_ready)
    // an item in stage 1 moves into an empty stage 2
    `MLS_ASSERT_NXT(a_stage_advance, aclk, aresetn, face_valid && !delta_valid, delta_valid)

endmodule

`default_nettype wire

// File: tb/sv/mls_slope_checker.sv
// Checker for the limited slope block: predicts each slope and compares it on the output channel
`timescale 1ns / 100ps

module mls_slope_checker
    import mls_pkg::*;
(
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [1:0]                        cfg_wr_data,
    input  logic                              s_valid,
    input  logic                              s_ready,
    input  logic [1:0]                        s_req_type,
    input  logic signed [MLS_DATA_BITS-1:0]   s_centre_a,
    input  logic signed [MLS_DATA_BITS-1:0]   s_plus_a,
    input  logic signed [MLS_DATA_BITS-1:0]   s_minus_a,
    input  logic signed [MLS_DATA_BITS-1:0]   s_centre_b,
    input  logic signed [MLS_DATA_BITS-1:0]   s_plus_b,
    input  logic signed [MLS_DATA_BITS-1:0]   s_minus_b,
    input  logic                              m_valid,
    input  logic                              m_ready,
    input  logic signed [MLS_DATA_BITS:0]     m_slope,
    output int                                mismatches,
    output int                                pending
);

    localparam int DW = MLS_DATA_BITS;

    logic [1:0]          limiter_kind;
    logic signed [DW:0]  predicted_slopes [$];
    logic signed [DW:0]  want;
    int                  err_count;

    function automatic longint limited_slope(input longint c, input longint p, input longint m,
                                             input logic [1:0] kind);
        longint k, dl, dr, dd, lim, half, adl, adr;
        if (kind != KIND_MINMOD && kind != KIND_MC)
            return 0;
        k = (kind == KIND_MC) ? 2 : 1;
        dl = k * (c - m);
        dr = k * (p - c);
        dd = p - m;
        adl = (dl < 0) ? -dl : dl;
        adr = (dr < 0) ? -dr : dr;
        if (dl == 0 || dr == 0 || ((dl < 0) != (dr < 0)))
            lim = 0;
        else
            lim = (adl < adr) ? adl : adr;
        // magnitude halving truncates
        half = ((dd < 0) ? -dd : dd) >>> 1;
        if (half < lim)
            lim = half;
        return (dd >= 0) ? lim : -lim;
    endfunction

    function automatic logic signed [DW:0] predict_slope(
        input logic [1:0] kind, input logic [1:0] rt,
        input logic signed [DW-1:0] ca, input logic signed [DW-1:0] pa,
        input logic signed [DW-1:0] ma, input logic signed [DW-1:0] cb,
        input logic signed [DW-1:0] pb, input logic signed [DW-1:0] mb);
        longint r;
        case (rt)
            REQ_SCALAR: r = limited_slope(longint'(ca), longint'(pa), longint'(ma), kind);
            // face average: arithmetic shift, rounds toward minus infinity
            REQ_MAG:    r = limited_slope((longint'(ca) + longint'(cb)) >>> 1,
                                          (longint'(pa) + longint'(pb)) >>> 1,
                                          (longint'(ma) + longint'(mb)) >>> 1, kind);
            REQ_FACE:   r = longint'(cb) - longint'(ca);
            default:    r = 0;
        endcase
        return r[DW:0];
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            limiter_kind = KIND_MINMOD;
            predicted_slopes.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (predicted_slopes.size() == 0) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("%0t: unexpected slope transfer %0d, none pending",
                                 $realtime, m_slope);
                end else begin
                    want = predicted_slopes.pop_front();
                    if (want !== m_slope) begin
                        err_count++;
                        if (err_count <= 10)
                            $display("%0t: slope mismatch, expected %0d got %0d",
                                     $realtime, want, m_slope);
                    end
                end
            end
            if (s_valid && s_ready)
                predicted_slopes.push_back(predict_slope(limiter_kind, s_req_type,
                                                         s_centre_a, s_plus_a, s_minus_a,
                                                         s_centre_b, s_plus_b, s_minus_b));
            if (cfg_wr_en)
                limiter_kind = cfg_wr_data;
        end
        mismatches <= err_count;
        pending    <= predicted_slopes.size();
    end

endmodule

// File: tb/sv/testbench.sv
// Top of the limited slope testbench: clock, reset, stimulus, stalls and verdict
`timescale 1ns / 100ps

module testbench;
    import mls_pkg::*;

    localparam int DW          = MLS_DATA_BITS;
    localparam int PIPE_DEPTH  = 5;
    localparam int END_WAIT    = 4 * PIPE_DEPTH;
    localparam int IDLE_LIMIT  = 2000;
    localparam int VMAX        = 2147483647;
    localparam int VMIN        = -2147483647 - 1;
    localparam int ONE         = 1 << 16;

    localparam logic [1:0] KIND_OFF    = 2'd0;
    localparam logic [1:0] KIND_RSVD   = 2'd3;
    localparam logic [1:0] REQ_UNKNOWN = 2'd3;

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic [1:0]            cfg_wr_data = 2'd0;
    logic                  s_valid     = 1'b0;
    logic                  s_ready;
    logic [1:0]            s_req_type  = 2'd0;
    logic signed [DW-1:0]  s_centre_a  = '0;
    logic signed [DW-1:0]  s_plus_a    = '0;
    logic signed [DW-1:0]  s_minus_a   = '0;
    logic signed [DW-1:0]  s_centre_b  = '0;
    logic signed [DW-1:0]  s_plus_b    = '0;
    logic signed [DW-1:0]  s_minus_b   = '0;
    logic                  m_valid;
    logic                  m_ready     = 1'b0;
    logic signed [DW:0]    m_slope;

    int mismatches;
    int pending;
    int burst_left  = 0;
    int idle_cycles = 0;
    int stall_cycle = 0;
    int stall_mode  = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    mhd_limited_slope u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_req_type  (s_req_type),
        .s_centre_a  (s_centre_a),
        .s_plus_a    (s_plus_a),
        .s_minus_a   (s_minus_a),
        .s_centre_b  (s_centre_b),
        .s_plus_b    (s_plus_b),
        .s_minus_b   (s_minus_b),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_slope     (m_slope)
    );

    mls_slope_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_req_type  (s_req_type),
        .s_centre_a  (s_centre_a),
        .s_plus_a    (s_plus_a),
        .s_minus_a   (s_minus_a),
        .s_centre_b  (s_centre_b),
        .s_plus_b    (s_plus_b),
        .s_minus_b   (s_minus_b),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_slope     (m_slope),
        .mismatches  (mismatches),
        .pending     (pending)
    );

    // receiver stall pattern, with a randomly redrawn stall mode
    always @(posedge aclk) begin
        stall_cycle <= stall_cycle + 1;
        if (stall_cycle % 64 == 0)
            stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0:       m_ready <= 1'b1;
            1:       m_ready <= 1'($urandom_range(0, 1));
            2:       m_ready <= ($urandom_range(0, 3) == 0);
            default: m_ready <= (stall_cycle % 3 == 0);
        endcase
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("mhd_limited_slope regression: fail");
                $finish;
            end
        end
    end

    task automatic send(input logic [1:0] rt, input int ca, input int pa, input int ma,
                        input int cb, input int pb, input int mb);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 6);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
        s_valid    <= 1'b1;
        s_req_type <= rt;
        s_centre_a <= ca;
        s_plus_a   <= pa;
        s_minus_a  <= ma;
        s_centre_b <= cb;
        s_plus_b   <= pb;
        s_minus_b  <= mb;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        burst_left--;
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    task automatic set_limiter(input logic [1:0] kind);
        drain_results();
        repeat (PIPE_DEPTH) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= kind;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic int rand_delta();
        int mag;
        case ($urandom_range(0, 3))
            0:       mag = 0;
            1:       mag = $urandom_range(1, 255);
            2:       mag = $urandom_range(1, 1 << 20);
            default: mag = $urandom >> $urandom_range(1, 31);
        endcase
        return $urandom_range(0, 1) ? mag : -mag;
    endfunction

    function automatic int rand_value();
        int v;
        case ($urandom_range(0, 7))
            0: begin
                case ($urandom_range(0, 4))
                    0:       v = VMIN;
                    1:       v = VMAX;
                    2:       v = 0;
                    3:       v = -1;
                    default: v = 1;
                endcase
            end
            1, 2:    v = rand_delta();
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic directed_stencils();
        send(REQ_SCALAR, 0, 0, 0, $urandom, $urandom, $urandom);
        send(REQ_SCALAR, 2 * ONE, 5 * ONE, ONE, $urandom, $urandom, $urandom);
        send(REQ_SCALAR, 2 * ONE, ONE, 5 * ONE, $urandom, $urandom, $urandom);
        send(REQ_SCALAR, 3 * ONE, ONE, 0, $urandom, $urandom, $urandom);
        send(REQ_SCALAR, 0, VMAX, VMIN, $urandom, $urandom, $urandom);
        send(REQ_SCALAR, 0, VMIN, VMAX, $urandom, $urandom, $urandom);
        send(REQ_SCALAR, VMIN, VMAX, VMIN, $urandom, $urandom, $urandom);
        // odd negative span, halving truncates toward zero
        send(REQ_SCALAR, -1, -3, 0, $urandom, $urandom, $urandom);
        send(REQ_MAG, VMAX, VMAX, VMIN, VMAX, VMAX, VMIN);
        // odd face sums round toward minus infinity
        send(REQ_MAG, 0, 3, -1, 1, 0, 0);
        send(REQ_FACE, VMIN, $urandom, $urandom, VMAX, $urandom, $urandom);
        send(REQ_FACE, VMAX, $urandom, $urandom, VMIN, $urandom, $urandom);
        send(REQ_UNKNOWN, ONE, 3 * ONE, 0, $urandom, $urandom, $urandom);
    endtask

    task automatic send_random();
        int pick, cm, cc, cp, d1, d2, spread;
        logic [1:0] rt;
        pick = $urandom_range(0, 99);
        rt = (pick < 40) ? REQ_SCALAR : (pick < 75) ? REQ_MAG :
             (pick < 95) ? REQ_FACE : REQ_UNKNOWN;
        if ($urandom_range(0, 9) < 7) begin
            cm = rand_value();
            d1 = rand_delta();
            d2 = rand_delta();
            if ($urandom_range(0, 4) != 0 && ((d1 < 0) != (d2 < 0)))
                d2 = -d2;
            cc = cm + d1;
            cp = cc + d2;
            case (rt)
                REQ_MAG: begin
                    spread = rand_delta();
                    send(rt, cc + spread, cp - spread, cm + spread,
                         cc - spread + $urandom_range(0, 1), cp + spread + $urandom_range(0, 1),
                         cm - spread + $urandom_range(0, 1));
                end
                REQ_FACE: send(rt, cc, $urandom, $urandom, cp, $urandom, $urandom);
                default:  send(rt, cc, cp, cm, $urandom, $urandom, $urandom);
            endcase
        end else begin
            send(rt, rand_value(), rand_value(), rand_value(),
                 rand_value(), rand_value(), rand_value());
        end
    endtask

    initial begin
        logic [1:0] phase_kind [7];
        int         phase_len  [7];
        phase_kind = '{KIND_MC, KIND_MINMOD, KIND_OFF, KIND_MC, KIND_RSVD, KIND_MINMOD, KIND_MC};
        phase_len  = '{150, 150, 40, 150, 40, 100, 100};

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        directed_stencils();
        set_limiter(KIND_MC);
        directed_stencils();

        for (int ph = 0; ph < 7; ph++) begin
            set_limiter(phase_kind[ph]);
            for (int n = 0; n < phase_len[ph]; n++) begin
                if ($urandom_range(0, 99) == 0)
                    drain_results();
                send_random();
            end
        end

        drain_results();
        repeat (END_WAIT) @(posedge aclk);
        if (mismatches == 0 && pending == 0)
            $display("mhd_limited_slope regression: pass");
        else
            $display("mhd_limited_slope regression: fail");
        $finish;
    end

endmodule

// File: mhd_limited_slope.f
+incdir+rtl
rtl/mls_pkg.sv
rtl/mls_face.sv
rtl/mls_delta.sv
rtl/mls_limit.sv
rtl/mhd_limited_slope.sv
tb/sv/mls_slope_checker.sv
tb/sv/testbench.sv
